### rtl/core/ipwq_pkg.sv
`default_nettype none

package ipwq_pkg;

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;
  localparam int WAIT_BITS   = 32;

  typedef logic [OP_BITS-1:0]     opcode_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam opcode_t OP_CLEAR  = 2'd0;
  localparam opcode_t OP_INSERT = 2'd1;
  localparam opcode_t OP_QUERY  = 2'd2;

  localparam status_t ST_INSIDE = 2'd0;
  localparam status_t ST_WAIT   = 2'd1;
  localparam status_t ST_NONE   = 2'd2;

endpackage

`default_nettype wire

### rtl/core/interval_point_wait_query_top.sv
// Clear and insert items complete on accept; the block is ready again on the next cycle.
// A query scans the stored intervals through one compare unit, one entry per cycle out of
// a registered table read, then loads its result into the output register from S_OUT.
// The block takes no new item until the result is loaded into the output register.
// Reset (rst_n low, synchronous) empties the table, clears the overflow flag and
// drops any pending result; the table contents themselves are not cleared.
`default_nettype none

module interval_point_wait_query_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int TIME_BITS     = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [ipwq_pkg::OP_BITS-1:0]       in_opcode,
  input  wire  [TIME_BITS-1:0]               in_start_time,
  input  wire  [TIME_BITS-1:0]               in_finish_time,
  input  wire  [TIME_BITS-1:0]               in_query_time,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [ipwq_pkg::STATUS_BITS-1:0]   out_status,
  output logic [ipwq_pkg::WAIT_BITS-1:0]     out_wait_amount,
  output logic                               out_overflow_seen
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [2*TIME_BITS-1:0] table_mem [TABLE_ENTRIES];

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [2*TIME_BITS-1:0] rd_data_r;
  logic [TIME_BITS-1:0] point_r, point_nxt;
  logic                 inside_r, inside_nxt;
  logic                 later_r, later_nxt;
  logic [TIME_BITS-1:0] best_r, best_nxt;

  logic                        out_valid_r, out_valid_nxt;
  ipwq_pkg::status_t           out_status_r, out_status_nxt;
  logic [ipwq_pkg::WAIT_BITS-1:0] out_wait_r, out_wait_nxt;
  logic                        out_ovf_r, out_ovf_nxt;

  logic                 accept;
  logic                 issue;
  logic                 wr_en;
  logic [TIME_BITS-1:0] rd_start;
  logic [TIME_BITS-1:0] rd_end;
  logic [TIME_BITS-1:0] diff;
  logic [63:0]          diff_ext;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = (state_r == S_SCAN) && (scan_r != count_r);
  assign wr_en    = accept && (in_opcode == ipwq_pkg::OP_INSERT) && (count_r != FULL_CNT);

  assign rd_start = rd_data_r[2*TIME_BITS-1:TIME_BITS];
  assign rd_end   = rd_data_r[TIME_BITS-1:0];
  assign diff     = best_r - point_r;
  assign diff_ext = 64'(diff);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[count_r[IDX_W-1:0]] <= {in_start_time, in_finish_time};
    end
    if (issue) begin
      rd_data_r <= table_mem[scan_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    scan_nxt       = scan_r;
    rd_vld_nxt     = issue;
    point_nxt      = point_r;
    inside_nxt     = inside_r;
    later_nxt      = later_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_wait_nxt   = out_wait_r;
    out_ovf_nxt    = out_ovf_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            ipwq_pkg::OP_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            ipwq_pkg::OP_INSERT: begin
              if (count_r != FULL_CNT) begin
                count_nxt = count_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            ipwq_pkg::OP_QUERY: begin
              point_nxt  = in_query_time;
              inside_nxt = 1'b0;
              later_nxt  = 1'b0;
              best_nxt   = '0;
              scan_nxt   = '0;
              state_nxt  = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_nxt = scan_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if ((rd_start <= point_r) && (point_r < rd_end)) begin
            inside_nxt = 1'b1;
          end
          if ((rd_start > point_r) && (!later_r || (rd_start < best_r))) begin
            best_nxt  = rd_start;
            later_nxt = 1'b1;
          end
        end
        if (!issue && !rd_vld_r) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          if (inside_r) begin
            out_status_nxt = ipwq_pkg::ST_INSIDE;
            out_wait_nxt   = '0;
          end else if (later_r) begin
            out_status_nxt = ipwq_pkg::ST_WAIT;
            out_wait_nxt   = diff_ext[ipwq_pkg::WAIT_BITS-1:0];
          end else begin
            out_status_nxt = ipwq_pkg::ST_NONE;
            out_wait_nxt   = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      scan_r      <= scan_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    point_r      <= point_nxt;
    inside_r     <= inside_nxt;
    later_r      <= later_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_wait_r   <= out_wait_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_wait_amount   = out_wait_r;
  assign out_overflow_seen = out_ovf_r;

endmodule

`default_nettype wire

### rtl/core/ipwq_checker.sv
`default_nettype none

module ipwq_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire [ipwq_pkg::OP_BITS-1:0]        in_opcode,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire [ipwq_pkg::STATUS_BITS-1:0]    out_status,
  input wire [ipwq_pkg::WAIT_BITS-1:0]      out_wait_amount
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_wait_amount))
    else $error("stalled result changed");

  // a query keeps the block busy for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == ipwq_pkg::OP_QUERY) |=> !in_ready)
    else $error("ready after query accept");

  // clear and insert leave the block ready again on the next cycle
  a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_opcode == ipwq_pkg::OP_CLEAR) ||
    (in_opcode == ipwq_pkg::OP_INSERT)) |=> in_ready)
    else $error("table update did not finish in one cycle");

  // only a wait answer carries a nonzero amount
  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ipwq_pkg::ST_WAIT) |-> (out_wait_amount == '0))
    else $error("nonzero wait amount without wait status");

endmodule

bind interval_point_wait_query_top ipwq_checker u_ipwq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_opcode      (in_opcode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_wait_amount(out_wait_amount)
);

`default_nettype wire
